### rtl/ycc565_pkg.sv
// ----------------------------------------------------------------------------
// ycc565_pkg
// Shared types and constants for the 4:2:2 pixel pair to RGB565 converter.
// ----------------------------------------------------------------------------
package ycc565_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PIX_W       = 16;
  localparam int unsigned MAG_W       = 18;
  localparam int unsigned TERM_W      = 21;
  localparam int unsigned DELTA_W     = 9;

  localparam int          CHROMA_BIAS = 128;
  localparam int          COEF_R_CR   = 1402;
  localparam int          COEF_G_CB   = 344;
  localparam int          COEF_G_CR   = 714;
  localparam int          COEF_B_CB   = 1772;
  localparam int          HALF_UNIT   = 500;
  localparam int          UNIT        = 1000;
  localparam int          COLOR_MAX   = 255;

  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned RECIP_W     = 19;
  localparam int unsigned RECIP_1K    = ((1 << RECIP_SHIFT) + UNIT - 1) / UNIT;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } term_t;

endpackage

### rtl/ycc565_term_div.sv
// ----------------------------------------------------------------------------
// ycc565_term_div
// Divides a biased chroma term magnitude by one thousand and restores its sign.
// ----------------------------------------------------------------------------
module ycc565_term_div (
  input  ycc565_pkg::term_t                          term,
  output logic signed [ycc565_pkg::DELTA_W-1:0]      delta
);
  import ycc565_pkg::*;

  localparam int unsigned PROD_W = MAG_W + RECIP_W;

  logic [PROD_W-1:0]  prod;
  logic [BYTE_W-1:0]  quot;

  // The magnitude already carries the half unit, so a floor division rounds.
  assign prod = PROD_W'(term.mag) * PROD_W'(RECIP_1K);
  assign quot = prod[RECIP_SHIFT +: BYTE_W];

  always_comb begin
    if (term.neg) begin
      delta = -$signed({1'b0, quot});
    end else begin
      delta = $signed({1'b0, quot});
    end
  end

endmodule

### rtl/ycbcr422_pair_to_rgb565_top.sv
// ----------------------------------------------------------------------------
// ycbcr422_pair_to_rgb565_top
// Converts one 4:2:2 pixel pair to two RGB565 pixels with BT.601 full range.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while out_ready takes the results; the first
// stage forms and registers the chroma products, the second divides them by
// one thousand and clamps and packs both pixels into the output registers.
// Reset empties both stages; no item is held after reset.
module ycbcr422_pair_to_rgb565_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ycc565_pkg::BYTE_W-1:0] in_first_luma,
  input  logic [ycc565_pkg::BYTE_W-1:0] in_second_luma,
  input  logic [ycc565_pkg::BYTE_W-1:0] in_blue_chroma,
  input  logic [ycc565_pkg::BYTE_W-1:0] in_red_chroma,
  input  logic                          in_frame_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ycc565_pkg::PIX_W-1:0]  out_first_pixel,
  output logic [ycc565_pkg::PIX_W-1:0]  out_second_pixel,
  output logic                          out_frame_end_out
);
  import ycc565_pkg::*;

  logic signed [DELTA_W-1:0] cb_s;
  logic signed [DELTA_W-1:0] cr_s;
  logic signed [TERM_W-1:0]  t_r;
  logic signed [TERM_W-1:0]  t_g;
  logic signed [TERM_W-1:0]  t_b;
  term_t                     term_r_nxt;
  term_t                     term_g_nxt;
  term_t                     term_b_nxt;

  logic                      s1_valid_r;
  logic                      s1_ready;
  logic                      out_en;
  term_t                     term_r_r;
  term_t                     term_g_r;
  term_t                     term_b_r;
  logic [BYTE_W-1:0]         y0_r;
  logic [BYTE_W-1:0]         y1_r;
  logic                      fe_r;

  logic signed [DELTA_W-1:0] d_r;
  logic signed [DELTA_W-1:0] d_g;
  logic signed [DELTA_W-1:0] d_b;
  logic [PIX_W-1:0]          pix0_nxt;
  logic [PIX_W-1:0]          pix1_nxt;

  logic                      out_valid_r;
  logic [PIX_W-1:0]          pix0_r;
  logic [PIX_W-1:0]          pix1_r;
  logic                      fe_out_r;

  function automatic term_t to_term(input logic signed [TERM_W-1:0] t);
    logic [TERM_W-1:0] mag;
    term_t             res;
    mag     = t[TERM_W-1] ? TERM_W'(-t) : TERM_W'(t);
    res.neg = t[TERM_W-1];
    res.mag = MAG_W'(mag + TERM_W'(HALF_UNIT));
    return res;
  endfunction

  function automatic logic [BYTE_W-1:0] sat_color(
    input logic [BYTE_W-1:0]         luma,
    input logic signed [DELTA_W-1:0] d
  );
    logic signed [DELTA_W+1:0] sum;
    logic [BYTE_W-1:0]         res;
    sum = $signed({2'b00, luma}) + (DELTA_W+2)'(d);
    if (sum < 0) begin
      res = '0;
    end else if (sum > (DELTA_W+2)'(COLOR_MAX)) begin
      res = BYTE_W'(COLOR_MAX);
    end else begin
      res = sum[BYTE_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] pack565(
    input logic [BYTE_W-1:0] r,
    input logic [BYTE_W-1:0] g,
    input logic [BYTE_W-1:0] b
  );
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // First stage: signed chroma and the three terms in thousandths.
  assign cb_s = $signed({1'b0, in_blue_chroma}) - DELTA_W'(CHROMA_BIAS);
  assign cr_s = $signed({1'b0, in_red_chroma}) - DELTA_W'(CHROMA_BIAS);

  assign t_r = TERM_W'(cr_s) * TERM_W'(COEF_R_CR);
  assign t_g = -(TERM_W'(cb_s) * TERM_W'(COEF_G_CB)) - TERM_W'(cr_s) * TERM_W'(COEF_G_CR);
  assign t_b = TERM_W'(cb_s) * TERM_W'(COEF_B_CB);

  assign term_r_nxt = to_term(t_r);
  assign term_g_nxt = to_term(t_g);
  assign term_b_nxt = to_term(t_b);

  assign out_en   = !out_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || out_en;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      term_r_r <= term_r_nxt;
      term_g_r <= term_g_nxt;
      term_b_r <= term_b_nxt;
      y0_r     <= in_first_luma;
      y1_r     <= in_second_luma;
      fe_r     <= in_frame_end;
    end
  end

  // Second stage: rounding division, clamping and packing.
  ycc565_term_div u_div_r (.term(term_r_r), .delta(d_r));
  ycc565_term_div u_div_g (.term(term_g_r), .delta(d_g));
  ycc565_term_div u_div_b (.term(term_b_r), .delta(d_b));

  assign pix0_nxt = pack565(sat_color(y0_r, d_r), sat_color(y0_r, d_g),
                            sat_color(y0_r, d_b));
  assign pix1_nxt = pack565(sat_color(y1_r, d_r), sat_color(y1_r, d_g),
                            sat_color(y1_r, d_b));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid_r) begin
      pix0_r   <= pix0_nxt;
      pix1_r   <= pix1_nxt;
      fe_out_r <= fe_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_first_pixel   = pix0_r;
  assign out_second_pixel  = pix1_r;
  assign out_frame_end_out = fe_out_r;

endmodule

### rtl/ycc565_chk.sv
// ----------------------------------------------------------------------------
// ycc565_chk
// Port-level checks for the pixel pair converter, bound to its top level.
// ----------------------------------------------------------------------------
module ycc565_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ycc565_pkg::PIX_W-1:0]  out_first_pixel,
  input logic [ycc565_pkg::PIX_W-1:0]  out_second_pixel,
  input logic                          out_frame_end_out
);

  // A stalled result item keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_first_pixel) &&
      $stable(out_second_pixel) && $stable(out_frame_end_out))
    else $error("stalled result item changed");

  // Reset leaves no result item pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The input side only stalls when a result item is held back downstream.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without downstream back-pressure");

endmodule

bind ycbcr422_pair_to_rgb565_top ycc565_chk u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_first_pixel   (out_first_pixel),
  .out_second_pixel  (out_second_pixel),
  .out_frame_end_out (out_frame_end_out)
);

### bench/ycc565_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycc565_checker
// Watches both channels of the pixel pair converter and checks its results.
// Every item accepted on the input side is converted here to the two RGB565
// pixels it must yield. The expectations are kept in order, and each accepted
// result is compared with the oldest of them, field by field.
// ----------------------------------------------------------------------------
module ycc565_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [ycc565_pkg::BYTE_W-1:0] in_first_luma,
  input  logic [ycc565_pkg::BYTE_W-1:0] in_second_luma,
  input  logic [ycc565_pkg::BYTE_W-1:0] in_blue_chroma,
  input  logic [ycc565_pkg::BYTE_W-1:0] in_red_chroma,
  input  logic                          in_frame_end,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [ycc565_pkg::PIX_W-1:0]  out_first_pixel,
  input  logic [ycc565_pkg::PIX_W-1:0]  out_second_pixel,
  input  logic                          out_frame_end_out,
  output int                            fail_count,
  output int                            pending_count
);

  localparam int RED_FROM_CR   = 1402;
  localparam int GREEN_FROM_CB = -344;
  localparam int GREEN_FROM_CR = -714;
  localparam int BLUE_FROM_CB  = 1772;
  localparam int MILLI_HALF    = 500;
  localparam int MILLI         = 1000;
  localparam int CHROMA_ZERO   = 128;
  localparam int LEVEL_MAX     = 255;

  typedef struct packed {
    logic [ycc565_pkg::PIX_W-1:0] first_pixel;
    logic [ycc565_pkg::PIX_W-1:0] second_pixel;
    logic                         frame_end;
  } pixel_pair_t;

  pixel_pair_t pending_pairs[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  function automatic int round_milli(input int v);
    if (v >= 0) begin
      return (v + MILLI_HALF) / MILLI;
    end
    return -((-v + MILLI_HALF) / MILLI);
  endfunction

  function automatic logic [7:0] clamp_level(input int v);
    if (v < 0) begin
      return 8'd0;
    end
    if (v > LEVEL_MAX) begin
      return 8'(LEVEL_MAX);
    end
    return 8'(v);
  endfunction

  function automatic logic [15:0] pack_rgb565(input int luma, input int dr, input int dg,
                                              input int db);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = clamp_level(luma + dr);
    g = clamp_level(luma + dg);
    b = clamp_level(luma + db);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic pixel_pair_t convert_pair(input logic [7:0] y0, input logic [7:0] y1,
                                               input logic [7:0] cb_byte,
                                               input logic [7:0] cr_byte,
                                               input logic frame_end);
    pixel_pair_t pair;
    int          cb;
    int          cr;
    int          dr;
    int          dg;
    int          db;
    cb = int'(cb_byte) - CHROMA_ZERO;
    cr = int'(cr_byte) - CHROMA_ZERO;
    dr = round_milli(RED_FROM_CR * cr);
    dg = round_milli(GREEN_FROM_CB * cb + GREEN_FROM_CR * cr);
    db = round_milli(BLUE_FROM_CB * cb);
    pair.first_pixel  = pack_rgb565(int'(y0), dr, dg, db);
    pair.second_pixel = pack_rgb565(int'(y1), dr, dg, db);
    pair.frame_end    = frame_end;
    return pair;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pixel_pair_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_pairs.push_back(convert_pair(in_first_luma, in_second_luma, in_blue_chroma,
                                             in_red_chroma, in_frame_end));
      end
      if (out_valid && out_ready) begin
        if (pending_pairs.size() == 0) begin
          report_mismatch("result with no item pending", out_first_pixel, 16'h0000);
        end else begin
          want = pending_pairs.pop_front();
          if (out_first_pixel !== want.first_pixel) begin
            report_mismatch("first pixel", out_first_pixel, want.first_pixel);
          end
          if (out_second_pixel !== want.second_pixel) begin
            report_mismatch("second pixel", out_second_pixel, want.second_pixel);
          end
          if (out_frame_end_out !== want.frame_end) begin
            report_mismatch("frame end flag", 16'(out_frame_end_out), 16'(want.frame_end));
          end
        end
      end
      pending_count <= pending_pairs.size();
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the 4:2:2 pixel pair to RGB565 converter.
// A directed set covers the extremes, clamping and exact halves of the chroma
// terms; random pixel pairs follow under three patterns of idling on the two
// sides. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STALL_LIMIT    = 2000;
  localparam int ITEMS_PER_PASS = 250;

  logic        clk;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_ready;
  logic [7:0]  in_first_luma     = 8'd0;
  logic [7:0]  in_second_luma    = 8'd0;
  logic [7:0]  in_blue_chroma    = 8'd0;
  logic [7:0]  in_red_chroma     = 8'd0;
  logic        in_frame_end      = 1'b0;
  logic        out_valid;
  logic        out_ready         = 1'b0;
  logic [15:0] out_first_pixel;
  logic [15:0] out_second_pixel;
  logic        out_frame_end_out;

  int          fail_count;
  int          pending_count;
  int          send_idle_pct     = 21;
  int          recv_idle_pct     = 54;
  int          stall_cycles      = 0;

  ycbcr422_pair_to_rgb565_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_first_luma     (in_first_luma),
    .in_second_luma    (in_second_luma),
    .in_blue_chroma    (in_blue_chroma),
    .in_red_chroma     (in_red_chroma),
    .in_frame_end      (in_frame_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_first_pixel   (out_first_pixel),
    .out_second_pixel  (out_second_pixel),
    .out_frame_end_out (out_frame_end_out)
  );

  ycc565_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_first_luma     (in_first_luma),
    .in_second_luma    (in_second_luma),
    .in_blue_chroma    (in_blue_chroma),
    .in_red_chroma     (in_red_chroma),
    .in_frame_end      (in_frame_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_first_pixel   (out_first_pixel),
    .out_second_pixel  (out_second_pixel),
    .out_frame_end_out (out_frame_end_out),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'(118 + $urandom_range(0, 20));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_pair(input logic [7:0] y0, input logic [7:0] y1,
                           input logic [7:0] cb, input logic [7:0] cr,
                           input logic frame_end);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_first_luma  <= y0;
    in_second_luma <= y1;
    in_blue_chroma <= cb;
    in_red_chroma  <= cr;
    in_frame_end   <= frame_end;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes, neutral chroma and clamping at both ends of each colour.
    push_pair(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    push_pair(8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
    push_pair(8'h00, 8'hff, 8'h80, 8'h80, 1'b0);
    push_pair(8'hff, 8'h00, 8'h80, 8'hff, 1'b0);
    push_pair(8'h00, 8'h10, 8'h80, 8'h00, 1'b1);
    push_pair(8'hff, 8'h00, 8'hff, 8'h80, 1'b0);
    push_pair(8'h00, 8'hff, 8'h00, 8'h80, 1'b0);
    push_pair(8'h80, 8'h7f, 8'h00, 8'hff, 1'b1);
    push_pair(8'h80, 8'h7f, 8'hff, 8'h00, 1'b0);
    // Blue term exactly half way, positive and negative.
    push_pair(8'h40, 8'hc0, 8'hfd, 8'h80, 1'b0);
    push_pair(8'h40, 8'hc0, 8'h03, 8'h80, 1'b0);
    // Green term exactly half way, positive and negative.
    push_pair(8'h64, 8'h9b, 8'h81, 8'h52, 1'b0);
    push_pair(8'h64, 8'h9b, 8'h7f, 8'hae, 1'b1);
    push_pair(8'h55, 8'haa, 8'h55, 8'haa, 1'b0);
    push_pair(8'haa, 8'h55, 8'haa, 8'h55, 1'b1);

    for (int pass = 0; pass < 3; pass++) begin
      if (pass == 1) begin
        send_idle_pct = 54;
        recv_idle_pct = 21;
      end else if (pass == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < ITEMS_PER_PASS; n++) begin
        push_pair(pick_level(), pick_level(), pick_level(), pick_level(),
                  ($urandom_range(0, 15) == 0));
      end
    end
    in_valid <= 1'b0;

    while (pending_count != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
